>>> design/sbba_pkg.sv
// Shared types, constants and helper functions for the size-class block allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package sbba_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = 4;
  localparam int WORDS     = 32;
  localparam int WORD_W    = 5;
  localparam int BM_DEPTH  = SLOTS * WORDS;
  localparam int BM_AW     = SLOT_W + WORD_W;
  localparam int CLS_W     = 4;
  localparam int CNT_W     = 10;
  localparam int REC_W     = 4;
  localparam int IDX_W     = 10;
  localparam int SIZE_W    = 12;
  localparam int ADDR_W    = 16;
  localparam int OFF_W     = 12;
  localparam logic [SIZE_W-1:0] MAX_REQ = 12'd1024;
  localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } sbba_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PICK,
    S_OPEN,
    S_CLEAR,
    S_RD,
    S_CHK,
    S_FREE_CHK
  } sbba_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic         accept;
    logic         scan_init;
    logic         scan_step;
    logic         pick;
    logic         open_slot;
    logic         clr_step;
    logic         rd_issue;
    logic         srch_next;
    logic         alloc_commit;
    logic         free_rd;
    logic         free_commit;
    logic         finish;
    sbba_status_t fin_status;
  } sbba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic op;
    logic too_large;
    logic scan_last;
    logic best_ok;
    logic free_ok;
    logic clr_last;
    logic word_full;
    logic srch_last;
    logic slot_bad;
    logic idx_bad;
    logic bit_set;
    logic out_valid;
  } sbba_stat_t;

  // Blocks per pool for each size class
  function automatic logic [CNT_W-1:0] class_cap(input logic [CLS_W-1:0] c);
    logic [CNT_W-1:0] r;
    case (c)
      4'd0:    r = 10'd988;
      4'd1:    r = 10'd502;
      4'd2:    r = 10'd253;
      4'd3:    r = 10'd126;
      4'd4:    r = 10'd62;
      4'd5:    r = 10'd30;
      4'd6:    r = 10'd14;
      4'd7:    r = 10'd6;
      4'd8:    r = 10'd2;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // Smallest class whose block size covers the request
  function automatic logic [CLS_W-1:0] size_class(input logic [SIZE_W-1:0] s);
    logic [CLS_W-1:0] r;
    if (s <= 12'd4)        r = 4'd0;
    else if (s <= 12'd8)   r = 4'd1;
    else if (s <= 12'd16)  r = 4'd2;
    else if (s <= 12'd32)  r = 4'd3;
    else if (s <= 12'd64)  r = 4'd4;
    else if (s <= 12'd128) r = 4'd5;
    else if (s <= 12'd256) r = 4'd6;
    else if (s <= 12'd512) r = 4'd7;
    else                   r = 4'd8;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/sbba_in_if.sv
// Request channel: valid/ready handshake with op, size and block address.
// Depends on sbba_pkg for field widths.
`default_nettype none

interface sbba_in_if
  import sbba_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              op;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] block_addr;

  modport source (output valid, output op, output req_size, output block_addr, input ready);
  modport sink   (input valid, input op, input req_size, input block_addr, output ready);
endinterface

`default_nettype wire

>>> design/sbba_out_if.sv
// Result channel: valid/ready handshake with allocated address and status.
// Depends on sbba_pkg for field widths.
`default_nettype none

interface sbba_out_if
  import sbba_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] alloc_addr;
  logic [1:0]        status;

  modport source (output valid, output alloc_addr, output status, input ready);
  modport sink   (input valid, input alloc_addr, input status, output ready);
endinterface

`default_nettype wire

>>> design/sbba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sbba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/sbba_ctrl.sv
// Controller state machine for the allocator: sequences scan, open, clear,
// bitmap search and free. Depends on sbba_pkg.
`default_nettype none

module sbba_ctrl
  import sbba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire sbba_stat_t stat,
  output sbba_cmd_t       cmd
);

  sbba_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE) && !stat.out_valid;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.op == OP_FREE) begin
          if (stat.slot_bad || stat.idx_bad) state_next = S_IDLE;
          else state_next = S_FREE_CHK;
        end else if (stat.too_large) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_PICK;
      end
      S_PICK: begin
        if (stat.best_ok) state_next = S_RD;
        else if (stat.free_ok) state_next = S_OPEN;
        else state_next = S_IDLE;
      end
      S_OPEN:  state_next = S_CLEAR;
      S_CLEAR: begin
        if (stat.clr_last) state_next = S_RD;
      end
      S_RD:  state_next = S_CHK;
      S_CHK: begin
        if (!stat.word_full || stat.srch_last) state_next = S_IDLE;
        else state_next = S_RD;
      end
      S_FREE_CHK: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    cmd.fin_status = ST_OK;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid && in_ready;
      end
      S_DECODE: begin
        if (stat.op == OP_FREE) begin
          if (stat.slot_bad) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_BAD_FREE;
          end else if (stat.idx_bad) begin
            cmd.finish = 1'b1;
          end else begin
            cmd.free_rd = 1'b1;
          end
        end else if (stat.too_large) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_TOO_LARGE;
        end else begin
          cmd.scan_init = 1'b1;
        end
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_PICK: begin
        cmd.pick = 1'b1;
        if (!stat.best_ok && !stat.free_ok) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NO_SLOT;
        end
      end
      S_OPEN:  cmd.open_slot = 1'b1;
      S_CLEAR: cmd.clr_step = 1'b1;
      S_RD:    cmd.rd_issue = 1'b1;
      S_CHK: begin
        if (!stat.word_full) begin
          cmd.alloc_commit = 1'b1;
        end else if (stat.srch_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NO_SLOT;
        end else begin
          cmd.srch_next = 1'b1;
        end
      end
      S_FREE_CHK: begin
        cmd.free_commit = stat.bit_set;
        cmd.finish      = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/sbba_dp.sv
// Datapath for the allocator: request registers, slot table, scan and search
// pointers, bitmap RAM, address arithmetic and result register. Depends on sbba_pkg, sbba_ram.
`default_nettype none

module sbba_dp
  import sbba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sbba_cmd_t         cmd,
  output sbba_stat_t             stat,
  input  wire logic              in_op,
  input  wire logic [SIZE_W-1:0] in_size,
  input  wire logic [ADDR_W-1:0] in_addr,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [ADDR_W-1:0] out_addr,
  output logic      [1:0]        out_status
);

  // Request word
  logic              op_r;
  logic [SIZE_W-1:0] size_r;
  logic [OFF_W-1:0]  off_r;

  // Slot table
  logic             valid [SLOTS];
  logic [CLS_W-1:0] cls_t [SLOTS];
  logic [CNT_W-1:0] cnt   [SLOTS];
  logic [REC_W-1:0] rec   [SLOTS];

  // Scan and search state
  logic [SLOT_W-1:0] sel;
  logic [SLOT_W-1:0] scan_ptr;
  logic [SLOT_W-1:0] best;
  logic              best_ok;
  logic [REC_W-1:0]  best_rec;
  logic [SLOT_W-1:0] free_slot;
  logic              free_ok;
  logic [WORD_W-1:0] wptr;

  logic [31:0]       rdata;
  logic              ram_we;
  logic [BM_AW-1:0]  ram_waddr;
  logic [31:0]       ram_wdata;
  logic              ram_re;
  logic [BM_AW-1:0]  ram_raddr;

  logic [CLS_W-1:0]  cls;
  logic [SLOT_W-1:0] sidx;
  logic              s_valid;
  logic [CLS_W-1:0]  s_cls;
  logic [CNT_W-1:0]  s_cnt;
  logic [REC_W-1:0]  s_rec;
  logic              match;

  logic [12:0]       span;
  logic [12:0]       q;
  logic [IDX_W-1:0]  fidx;
  logic [CLS_W-1:0]  fsh;
  logic [4:0]        zbit;
  logic [IDX_W-1:0]  aidx;
  logic [20:0]       aoff;
  logic [ADDR_W-1:0] abase;
  logic [ADDR_W-1:0] aaddr;

  function automatic logic [4:0] first_zero(input logic [31:0] w);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!w[i]) r = 5'(i);
    end
    return r;
  endfunction

  assign cls = size_class(size_r);

  // One slot-table read port: scan pointer while scanning, else the chosen slot
  assign sidx    = cmd.scan_step ? scan_ptr : sel;
  assign s_valid = valid[sidx];
  assign s_cls   = cls_t[sidx];
  assign s_cnt   = cnt[sidx];
  assign s_rec   = rec[sidx];
  assign match   = s_valid && (s_cls == cls) && (s_cnt < class_cap(cls)) &&
                   (!best_ok || (s_rec < best_rec));

  // Block index of a free: floor((page - offset) / size) - 1
  assign fsh  = s_cls + 4'd2;
  assign span = 13'h1000 - {1'b0, off_r};
  assign q    = span >> fsh;
  assign fidx = IDX_W'(q - 13'd1);

  // Address of the block found by the search
  assign zbit  = first_zero(rdata);
  assign aidx  = {wptr, zbit};
  assign aoff  = (21'({aidx}) + 21'd1) << (cls + 4'd2);
  assign abase = {sel, 12'h000} + 16'h1000;
  assign aaddr = abase - aoff[ADDR_W-1:0];

  // Capture request word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_op;
      size_r <= in_size;
      off_r  <= in_addr[OFF_W-1:0];
    end
  end

  // Scan, pick and word pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= '0;
      scan_ptr  <= '0;
      best      <= '0;
      best_ok   <= 1'b0;
      best_rec  <= '0;
      free_slot <= '0;
      free_ok   <= 1'b0;
      wptr      <= '0;
    end else begin
      if (cmd.accept) begin
        sel <= in_addr[ADDR_W-1 -: SLOT_W];
      end
      if (cmd.scan_init) begin
        scan_ptr <= '0;
        best_ok  <= 1'b0;
        free_ok  <= 1'b0;
      end
      if (cmd.scan_step) begin
        scan_ptr <= scan_ptr + 1'b1;
        if (match) begin
          best     <= scan_ptr;
          best_ok  <= 1'b1;
          best_rec <= s_rec;
        end
        if (!s_valid && !free_ok) begin
          free_slot <= scan_ptr;
          free_ok   <= 1'b1;
        end
      end
      if (cmd.pick) begin
        sel  <= best_ok ? best : free_slot;
        wptr <= '0;
      end
      if (cmd.clr_step || cmd.srch_next) begin
        wptr <= wptr + 1'b1;
      end
    end
  end

  // Slot table updates: open, count up on alloc, count down and close on free
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < SLOTS; t++) begin
        valid[t] <= 1'b0;
        cls_t[t] <= '0;
        cnt[t]   <= '0;
        rec[t]   <= '0;
      end
    end else begin
      if (cmd.open_slot) begin
        for (int t = 0; t < SLOTS; t++) begin
          if (valid[t] && cls_t[t] == cls) rec[t] <= rec[t] + 1'b1;
        end
        valid[sel] <= 1'b1;
        cls_t[sel] <= cls;
        cnt[sel]   <= '0;
        rec[sel]   <= '0;
      end
      if (cmd.alloc_commit) begin
        cnt[sel] <= s_cnt + 1'b1;
      end
      if (cmd.free_commit) begin
        cnt[sel] <= s_cnt - 1'b1;
        if (s_cnt == CNT_W'(1)) begin
          for (int t = 0; t < SLOTS; t++) begin
            if (valid[t] && cls_t[t] == s_cls && rec[t] > s_rec) rec[t] <= rec[t] - 1'b1;
          end
          valid[sel] <= 1'b0;
          cls_t[sel] <= '0;
          rec[sel]   <= '0;
        end
      end
    end
  end

  // Bitmap RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {sel, wptr};
    ram_wdata = '0;
    if (cmd.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd.alloc_commit) begin
      ram_we    = 1'b1;
      ram_wdata = rdata | (32'd1 << zbit);
    end else if (cmd.free_commit) begin
      ram_we    = 1'b1;
      ram_waddr = {sel, fidx[IDX_W-1 -: WORD_W]};
      ram_wdata = rdata & ~(32'd1 << fidx[4:0]);
    end
  end

  assign ram_re    = cmd.rd_issue || cmd.free_rd;
  assign ram_raddr = cmd.free_rd ? {sel, fidx[IDX_W-1 -: WORD_W]} : {sel, wptr};

  sbba_ram #(
    .WIDTH (32),
    .DEPTH (BM_DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.alloc_commit || cmd.finish) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_commit) begin
      out_addr   <= aaddr;
      out_status <= ST_OK;
    end else if (cmd.finish) begin
      out_addr   <= '0;
      out_status <= cmd.fin_status;
    end
  end

  // Status to the controller
  always_comb begin
    stat.op        = op_r;
    stat.too_large = size_r > MAX_REQ;
    stat.scan_last = scan_ptr == SLOT_W'(SLOTS - 1);
    stat.best_ok   = best_ok;
    stat.free_ok   = free_ok;
    stat.clr_last  = wptr == WORD_W'(WORDS - 1);
    stat.word_full = rdata == FULL_WORD;
    stat.srch_last = wptr == WORD_W'(WORDS - 1);
    stat.slot_bad  = !s_valid;
    stat.idx_bad   = (q == 13'd0) || (fidx >= class_cap(s_cls));
    stat.bit_set   = rdata[fidx[4:0]];
    stat.out_valid = out_valid;
  end

endmodule

`default_nettype wire

>>> design/size_class_bitmap_block_allocator.sv
// Sequence: a free decodes, then reads and checks its bitmap word; an alloc decodes,
// runs the 16-slot scan, picks a pool and then reads and checks bitmap words in turn.
// An alloc that opens a page slot adds the open and a 32-word bitmap clear before the search;
// a search in an open pool may run through all 32 words.
// Throughput: one word at a time; the next word is taken once the result is delivered.
// Reset: synchronous, active high; clears the slot table and control state.
`default_nettype none

module size_class_bitmap_block_allocator
  import sbba_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  sbba_in_if.sink    in_ch,
  sbba_out_if.source out_ch
);

  sbba_cmd_t  cmd;
  sbba_stat_t stat;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_status;

  sbba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbba_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_ch.op),
    .in_size    (in_ch.req_size),
    .in_addr    (in_ch.block_addr),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_addr   (out_ch.alloc_addr),
    .out_status (out_status)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.status = out_status;

  // A new word is never taken while a result waits
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("ready raised while result pending");

  // One word in flight at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("ready held after accept");

  // Failed requests report address zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_ch.alloc_addr == '0))
    else $error("nonzero address on failed request");

endmodule

`default_nettype wire

>>> test/sbba_checker.sv
// Watches the request and result channels of the block allocator, predicts each result
// and compares it. Depends on sbba_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module sbba_checker
  import sbba_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  sbba_in_if       in_ch,
  sbba_out_if      out_ch,
  output int       fail_count,
  output int       pending
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    sbba_status_t      status;
  } alloc_result_t;

  logic             pool_open  [SLOTS];
  logic [CLS_W-1:0] pool_class [SLOTS];
  int               pool_used  [SLOTS];
  int               pool_age   [SLOTS];
  logic [31:0]      used_bits  [SLOTS][WORDS];
  alloc_result_t    expected_results[$];

  // Blocks per pool, worked out from the page geometry
  function automatic int pool_capacity(int c);
    int bs;
    int span;
    bs = 4 << c;
    span = 32 << c;
    return ((4096 - 16) / bs) * (span - 1) / span;
  endfunction

  function automatic alloc_result_t take_block(int size);
    alloc_result_t r;
    int c;
    int best;
    int idx;
    c = 0;
    best = -1;
    idx = -1;
    r.addr = '0;
    if (size > 1024) begin
      r.status = ST_TOO_LARGE;
      return r;
    end
    while ((4 << c) < size) c++;
    for (int s = 0; s < SLOTS; s++) begin
      if (pool_open[s] && pool_class[s] == c && pool_used[s] < pool_capacity(c) &&
          (best < 0 || pool_age[s] < pool_age[best]))
        best = s;
    end
    if (best < 0) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (!pool_open[s]) begin
          best = s;
          break;
        end
      end
      if (best < 0) begin
        r.status = ST_NO_SLOT;
        return r;
      end
      for (int s = 0; s < SLOTS; s++)
        if (pool_open[s] && pool_class[s] == c) pool_age[s]++;
      pool_open[best] = 1'b1;
      pool_class[best] = CLS_W'(c);
      pool_used[best] = 0;
      pool_age[best] = 0;
      for (int w = 0; w < WORDS; w++) used_bits[best][w] = '0;
    end
    for (int i = 0; i < WORDS * 32; i++) begin
      if (!used_bits[best][i/32][i%32]) begin
        idx = i;
        break;
      end
    end
    used_bits[best][idx/32][idx%32] = 1'b1;
    pool_used[best]++;
    r.addr = ADDR_W'((best * 4096 + 4096 - (4 << c) * (idx + 1)) & 32'h0000_FFFF);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic sbba_status_t release_block(int addr);
    int s;
    int c;
    int q;
    int idx;
    int r;
    s = addr / 4096;
    if (s >= SLOTS || !pool_open[s]) return ST_BAD_FREE;
    c = pool_class[s];
    if (c > 8) return ST_OK;
    q = (4096 - (addr % 4096)) / (4 << c);
    if (q == 0) return ST_OK;
    idx = q - 1;
    if (idx >= pool_capacity(c) || !used_bits[s][idx/32][idx%32]) return ST_OK;
    used_bits[s][idx/32][idx%32] = 1'b0;
    pool_used[s]--;
    if (pool_used[s] == 0) begin
      r = pool_age[s];
      pool_open[s] = 1'b0;
      for (int t = 0; t < SLOTS; t++)
        if (pool_open[t] && pool_class[t] == c && pool_age[t] > r) pool_age[t]--;
      pool_class[s] = '0;
      pool_age[s] = 0;
    end
    return ST_OK;
  endfunction

  // Predict on each accepted request word, compare on each accepted result word
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst) begin
      fail_count <= 0;
      pending <= 0;
      expected_results.delete();
      for (int s = 0; s < SLOTS; s++) begin
        pool_open[s] = 1'b0;
        pool_class[s] = '0;
        pool_used[s] = 0;
        pool_age[s] = 0;
        for (int w = 0; w < WORDS; w++) used_bits[s][w] = '0;
      end
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_ALLOC) begin
          e = take_block(in_ch.req_size);
        end else begin
          e.addr = '0;
          e.status = release_block(in_ch.block_addr);
        end
        expected_results.push_back(e);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: addr %h status %0d",
                     out_ch.alloc_addr, out_ch.status);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.alloc_addr !== e.addr || out_ch.status !== e.status) begin
            if (fail_count < 10)
              $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                       e.addr, e.status, out_ch.alloc_addr, out_ch.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

>>> test/tb.sv
// Stimulus and verdict for the size-class block allocator; the checker predicts.
// Depends on sbba_pkg, the channel interfaces, sbba_checker and the allocator.
`timescale 1ns / 1ps

module tb
  import sbba_pkg::*;
;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   hold_off = 0;
  logic [ADDR_W-1:0] live_blocks[$];

  sbba_in_if  in_ch ();
  sbba_out_if out_ch ();

  size_class_bitmap_block_allocator DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  sbba_checker chk (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                    .fail_count(fail_count), .pending(pending));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Track allocated addresses so frees mostly hit live blocks
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_ch.valid && out_ch.ready && out_ch.status == ST_OK && out_ch.alloc_addr != 0)
      live_blocks.push_back(out_ch.alloc_addr);
  end

  // Timeout
  always @(posedge clk) begin
    if (cycles > 600000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stall per word, with one long hold-off
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_word(logic op, int size, int addr);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.req_size <= SIZE_W'(size);
    in_ch.block_addr <= ADDR_W'(addr);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // Drop the word and wait before the next one
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_word();
    int k;
    int pick;
    int sz;
    k = $urandom_range(0, 99);
    if (k < 50) begin
      // Favor small classes so pools fill and roll over
      sz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 64);
      if (k < 3) sz = $urandom_range(0, 4095);
      send_word(OP_ALLOC, sz, $urandom_range(0, 65535));
    end else if (k < 92 && live_blocks.size() > 0) begin
      pick = $urandom_range(0, live_blocks.size() - 1);
      send_word(OP_FREE, $urandom_range(0, 4095), live_blocks[pick]);
      live_blocks.delete(pick);
    end else begin
      send_word(OP_FREE, $urandom_range(0, 4095), $urandom_range(0, 65535));
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_ALLOC;
    in_ch.req_size <= '0;
    in_ch.block_addr <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: top size of every class, oversize, bad and odd frees
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_ALLOC, 4, 16'hFFFF);
    send_word(OP_ALLOC, 5, 0);
    send_word(OP_ALLOC, 1024, 0);
    send_word(OP_ALLOC, 1025, 0);
    send_word(OP_ALLOC, 4095, 0);
    for (int c = 1; c <= 8; c++) send_word(OP_ALLOC, 4 << c, 0);
    send_word(OP_FREE, 4095, 16'hFFFF);
    send_word(OP_FREE, 0, 16'h0FFE);
    send_word(OP_FREE, 0, 16'h0FFC);
    send_word(OP_FREE, 0, 16'h0FFC);
    send_word(OP_FREE, 0, 16'h0000);
    send_word(OP_FREE, 0, 16'h1C00);
    send_word(OP_FREE, 0, 16'h1000);
    // Exhaust slots with 1024-byte pools (2 blocks each)
    for (int i = 0; i < 34; i++) send_word(OP_ALLOC, 1000, 0);

    // Pause until the block has drained
    while (pending != 0) @(posedge clk);

    // Free everything, then the random part
    live_blocks.shuffle();
    while (live_blocks.size() > 0) begin
      send_word(OP_FREE, 0, live_blocks.pop_front());
    end
    for (int n = 0; n < 1300; n++) begin
      if (n == 600) hold_off = 300;
      send_random_word();
    end

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
